[hw/rtl/swm_pkg.sv]
package swm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int NPOS        = PATTERN_MAX + 1;
	localparam int LEN_W       = 6;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] NUL_BYTE  = 8'h00;

	// register indexes (byte address is 8 times the index)
	localparam logic [2:0] REG_CHARS_LOW    = 3'd0;
	localparam logic [2:0] REG_CHARS_SECOND = 3'd1;
	localparam logic [2:0] REG_CHARS_THIRD  = 3'd2;
	localparam logic [2:0] REG_CHARS_HIGH   = 3'd3;
	localparam logic [2:0] REG_LENGTH       = 3'd4;

	// decoded pattern, shared by the register block and the step logic
	typedef struct packed {
		logic [PATTERN_MAX-1:0][7:0] chars;
		logic [PATTERN_MAX-1:0]      star;    // star inside the pattern
		logic [PATTERN_MAX-1:0]      lit;     // literal inside the pattern
		logic [NPOS-1:0]             posmask; // positions 0..len
		logic [NPOS-1:0]             endpos;  // one-hot: position len
	} pat_t;

	// star closure: a set position i reaches i+1 when byte i is a star.
	// Parallel-prefix scan, generate = set bit, propagate = star before it.
	function automatic logic [NPOS-1:0] closure(input logic [NPOS-1:0] set,
			input logic [PATTERN_MAX-1:0] star);
		logic [NPOS-1:0] g;
		logic [NPOS-1:0] p;
		logic [NPOS-1:0] g_n;
		logic [NPOS-1:0] p_n;
		g = set;
		p = {star, 1'b0};
		for (int d = 1; d < NPOS; d = d * 2) begin
			g_n = g;
			p_n = p;
			for (int j = d; j < NPOS; j++) begin
				g_n[j] = g[j] | (p[j] & g[j-d]);
				p_n[j] = p[j] & p[j-d];
			end
			g = g_n;
			p = p_n;
		end
		return g;
	endfunction

endpackage

[hw/rtl/star_wildcard_matcher.sv]
// Star-only glob matcher: the text streams in one byte per request and is
// matched against a pattern of up to 32 bytes held in the register port,
// where '*' stands for any run of bytes and every other byte matches
// itself; the pattern ends at its length or at its first zero byte,
// whichever comes first. A request with tuser low carries no character and
// leaves the match state alone; tlast ends the text (after its byte, if
// any), emits one verdict on the output stream and rearms for the next
// text. Throughput is one request per clock: the input register feeds an
// update of the 33-bit active-position set (byte compare plus a
// parallel-prefix star closure), and the verdict lands in an output
// register. Only an end request finding the output register still full
// holds the input back.
// Write the pattern registers only between texts or with the stream idle.
module star_wildcard_matcher (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [7:0] text_byte
	input  logic                        s_axis_tuser,  // [0] has_byte
	input  logic                        s_axis_tlast,  // end_of_text
	// verdict stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // [0] matched, [7:1] zero
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swm_pkg::ADDR_W-1:0]  paddr,
	input  logic [swm_pkg::DATA_W-1:0]  pwdata,
	output logic [swm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	swm_pkg::pat_t pat;
	logic          res_free;
	logic          res_load;
	logic          res_matched;
	logic          out_valid_q;
	logic          matched_q;

	assign pready = 1'b1;

	// pattern registers and their decode
	swm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pat     (pat)
	);

	// the verdict register is free when empty or being drained this cycle
	assign res_free = ~out_valid_q | m_axis_tready;

	// input register and position-set update
	swm_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.pat         (pat),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_has      (s_axis_tuser),
		.in_end      (s_axis_tlast),
		.res_free    (res_free),
		.res_load    (res_load),
		.res_matched (res_matched)
	);

	// hold the verdict until taken; a new one may load in the drain cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			matched_q <= res_matched;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, matched_q};

endmodule

[hw/rtl/swm_cfg.sv]
module swm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swm_pkg::ADDR_W-1:0]  paddr,
	input  logic [swm_pkg::DATA_W-1:0]  pwdata,
	output logic [swm_pkg::DATA_W-1:0]  prdata,
	output swm_pkg::pat_t               pat
);

	logic [3:0][63:0]              chars_q;
	logic [swm_pkg::LEN_W-1:0]     len_q;
	logic                          wr_en;
	logic [2:0]                    idx;
	logic [swm_pkg::LEN_W-1:0]     n_sat;
	logic [swm_pkg::PATTERN_MAX-1:0] nz;
	logic [swm_pkg::PATTERN_MAX-1:0] inpat;
	logic [swm_pkg::PATTERN_MAX-1:0] lowm;

	assign idx   = paddr[5:3];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			len_q   <= '0;
		end else if (wr_en) begin
			case (idx)
				swm_pkg::REG_CHARS_LOW:    chars_q[0] <= pwdata;
				swm_pkg::REG_CHARS_SECOND: chars_q[1] <= pwdata;
				swm_pkg::REG_CHARS_THIRD:  chars_q[2] <= pwdata;
				swm_pkg::REG_CHARS_HIGH:   chars_q[3] <= pwdata;
				swm_pkg::REG_LENGTH:       len_q      <= pwdata[swm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			swm_pkg::REG_CHARS_LOW:    prdata = chars_q[0];
			swm_pkg::REG_CHARS_SECOND: prdata = chars_q[1];
			swm_pkg::REG_CHARS_THIRD:  prdata = chars_q[2];
			swm_pkg::REG_CHARS_HIGH:   prdata = chars_q[3];
			swm_pkg::REG_LENGTH:       prdata = {{(swm_pkg::DATA_W-swm_pkg::LEN_W){1'b0}}, len_q};
			default:                   prdata = '0;
		endcase
	end

	// saturate the length, then cut the pattern at its first zero byte
	assign n_sat = (len_q > swm_pkg::LEN_W'(swm_pkg::PATTERN_MAX)) ?
		swm_pkg::LEN_W'(swm_pkg::PATTERN_MAX) : len_q;

	always_comb begin
		pat.chars = chars_q;
		for (int i = 0; i < swm_pkg::PATTERN_MAX; i++) begin
			nz[i] = (pat.chars[i] != swm_pkg::NUL_BYTE);
		end
		for (int i = 0; i < swm_pkg::PATTERN_MAX; i++) begin
			lowm     = {swm_pkg::PATTERN_MAX{1'b1}} >> (swm_pkg::PATTERN_MAX - 1 - i);
			inpat[i] = (swm_pkg::LEN_W'(i) < n_sat) && ((nz | ~lowm) == '1);
			pat.star[i] = inpat[i] && (pat.chars[i] == swm_pkg::STAR_BYTE);
			pat.lit[i]  = inpat[i] && (pat.chars[i] != swm_pkg::STAR_BYTE);
		end
		pat.posmask = {inpat, 1'b1};
		pat.endpos  = {inpat, 1'b1} & ~{1'b0, inpat};
	end

endmodule

[hw/rtl/swm_step.sv]
module swm_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swm_pkg::pat_t        pat,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_has,
	input  logic                 in_end,
	input  logic                 res_free,
	output logic                 res_load,
	output logic                 res_matched
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      has_s1;
	logic                      end_s1;
	logic [swm_pkg::NPOS-1:0]  act_q;
	logic [swm_pkg::NPOS-1:0]  cur;
	logic [swm_pkg::NPOS-1:0]  nxt;
	logic [swm_pkg::NPOS-1:0]  after;
	logic [swm_pkg::NPOS-1:0]  fin;
	logic                      adv;

	assign adv      = valid_s1 & (~end_s1 | res_free);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			has_s1  <= in_has;
			end_s1  <= in_end;
		end
	end

	always_comb begin
		cur = swm_pkg::closure(act_q & pat.posmask, pat.star);
		nxt = '0;
		for (int j = 0; j < swm_pkg::PATTERN_MAX; j++) begin
			nxt[j]   = nxt[j] | (cur[j] & pat.star[j]);
			nxt[j+1] = cur[j] & pat.lit[j] & (pat.chars[j] == byte_s1);
		end
		after = has_s1 ? nxt : act_q;
		fin   = swm_pkg::closure(after & pat.posmask, pat.star);
	end

	assign res_load    = adv & end_s1;
	assign res_matched = |(fin & pat.endpos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= swm_pkg::NPOS'(1);
		end else if (adv) begin
			act_q <= end_s1 ? swm_pkg::NPOS'(1) : after;
		end
	end

endmodule

[tb/sv/tb.sv]
module tb;
	import swm_pkg::*;

	// Run ceiling in clock cycles.
	localparam int CYCLE_LIMIT = 500000;
	// Requests per random phase, one phase per idling profile.
	localparam int PHASE_REQUESTS = 200;

	// One request on the text stream.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       has_byte;
		logic       end_of_text;
	} text_req_t;

	// Predicts match verdicts from the accepted requests. It holds its own
	// copy of the pattern registers and of the reachable-position set.
	class verdict_board;
		bit [8*PATTERN_MAX-1:0] pattern_word;
		bit [LEN_W-1:0]         length_reg;
		bit [NPOS-1:0]          reach;
		bit                     verdict_q[$];
		int                     mismatch_count;

		function new();
			pattern_word = '0;
			length_reg = '0;
			reach = 1;
			mismatch_count = 0;
		endfunction

		function void write_register(logic [2:0] idx, bit [DATA_W-1:0] value);
			case (idx)
			REG_CHARS_LOW:    pattern_word[63:0] = value;
			REG_CHARS_SECOND: pattern_word[127:64] = value;
			REG_CHARS_THIRD:  pattern_word[191:128] = value;
			REG_CHARS_HIGH:   pattern_word[255:192] = value;
			REG_LENGTH:       length_reg = value[LEN_W-1:0];
			default: ;
			endcase
		endfunction

		function bit [7:0] pattern_byte(int i);
			return pattern_word[8*i +: 8];
		endfunction

		// Length in use: saturate at the maximum, cut at the first zero byte.
		function int effective_length();
			int n;
			n = (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
			for (int i = 0; i < n; i++)
				if (pattern_byte(i) == NUL_BYTE)
					return i;
			return n;
		endfunction

		// Drop positions past the end, then let every star pass its position on.
		function bit [NPOS-1:0] star_closure(bit [NPOS-1:0] set, int n);
			for (int i = 0; i < NPOS; i++)
				if (i > n)
					set[i] = 1'b0;
			for (int i = 0; i < n; i++)
				if (set[i] && pattern_byte(i) == STAR_BYTE)
					set[i+1] = 1'b1;
			return set;
		endfunction

		function void note_request(bit [7:0] text_byte, bit has_byte, bit end_of_text);
			int n;
			bit [NPOS-1:0] cur;
			bit [NPOS-1:0] nxt;
			n = effective_length();
			if (has_byte) begin
				cur = star_closure(reach, n);
				nxt = '0;
				for (int i = 0; i < n; i++) begin
					if (cur[i]) begin
						if (pattern_byte(i) == STAR_BYTE)
							nxt[i] = 1'b1;
						else if (pattern_byte(i) == text_byte)
							nxt[i+1] = 1'b1;
					end
				end
				reach = nxt;
			end
			if (end_of_text) begin
				cur = star_closure(reach, n);
				verdict_q.insert(verdict_q.size(), cur[n]);
				reach = 1;
			end
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			mismatch_count++;
		endtask

		task check_verdict(logic [7:0] data);
			bit want;
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("verdict %h arrived with none pending", data));
				return;
			end
			want = verdict_q.pop_front();
			if (data[0] !== want)
				report_mismatch($sformatf("matched is %b, predicted %b", data[0], want));
			if (data[7:1] !== 7'd0)
				report_mismatch($sformatf("padding bits of verdict are %h", data[7:1]));
		endtask

		task check_drained();
			if (verdict_q.size() != 0)
				report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
		endtask

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;  // [7:0] text_byte
	logic                s_axis_tuser = 1'b0; // [0] has_byte
	logic                s_axis_tlast = 1'b0; // end_of_text
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [7:0]          m_axis_tdata;       // [0] matched, [7:1] zero
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	verdict_board verdicts = new();
	text_req_t    text_q[$];
	int           send_idle_pct = 0;
	int           rx_stall_pct = 0;
	int           sent_count = 0;
	int           cycle_count = 0;

	star_wildcard_matcher DUT (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run: a hung handshake ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: stall the verdict stream at random, redrawn every cycle.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

	// Watch both streams at the rising edge, before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				verdicts.note_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				verdicts.check_verdict(m_axis_tdata);
		end
	end

	function automatic void add_item(bit [7:0] b, bit has, bit last);
		text_req_t r;
		r.text_byte = b;
		r.has_byte = has;
		r.end_of_text = last;
		text_q.insert(text_q.size(), r);
	endfunction

	function automatic bit [8*PATTERN_MAX-1:0] str_to_chars(string s);
		bit [8*PATTERN_MAX-1:0] w;
		w = '0;
		for (int i = 0; i < s.len(); i++)
			w[8*i +: 8] = s[i];
		return w;
	endfunction

	// Mostly a small alphabet so that texts and patterns meet; now and then any byte.
	function automatic bit [7:0] any_letter();
		if ($urandom_range(99) < 85)
			return 8'h61 + 8'($urandom_range(2));
		return 8'($urandom_range(255));
	endfunction

	// Offer one request, idling first at the sender's rate; hold it until taken.
	task automatic send_request(text_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r.text_byte;
		s_axis_tuser  <= r.has_byte;
		s_axis_tlast  <= r.end_of_text;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		if (r.has_byte || r.end_of_text)
			sent_count++;
	endtask

	task automatic send_text();
		foreach (text_q[k])
			send_request(text_q[k]);
		text_q.delete();
	endtask

	// Drop valid, wait out every pending verdict, then let the pipeline drain:
	// a byte request with no verdict may still sit in the input register.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (verdicts.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge.
	task automatic apb_write(logic [2:0] idx, bit [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		verdicts.write_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic program_pattern(bit [8*PATTERN_MAX-1:0] chars, bit [DATA_W-1:0] len_word);
		settle();
		apb_write(REG_CHARS_LOW, chars[63:0]);
		apb_write(REG_CHARS_SECOND, chars[127:64]);
		apb_write(REG_CHARS_THIRD, chars[191:128]);
		apb_write(REG_CHARS_HIGH, chars[255:192]);
		apb_write(REG_LENGTH, len_word);
	endtask

	// Mostly short patterns; some long ones and some lengths past the maximum.
	// Bytes past the length are garbage on purpose.
	function automatic void random_pattern(output bit [8*PATTERN_MAX-1:0] w,
			output bit [DATA_W-1:0] len_word);
		int n;
		int pick;
		pick = $urandom_range(99);
		n = (pick < 70) ? $urandom_range(6) : (pick < 90) ? $urandom_range(32, 7)
			: $urandom_range(63, 33);
		for (int i = 0; i < PATTERN_MAX; i++) begin
			w[8*i +: 8] = 8'($urandom_range(255));
			if (i < n) begin
				pick = $urandom_range(99);
				if (pick < 30)
					w[8*i +: 8] = STAR_BYTE;
				else if (pick < 33)
					w[8*i +: 8] = NUL_BYTE;
				else if (pick < 95)
					w[8*i +: 8] = 8'h61 + 8'($urandom_range(2));
			end
		end
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = LEN_W'(n);
	endfunction

	// Build a text that fits the current pattern, then maybe break it; a tenth
	// are plain noise. Sprinkle requests without a character in between.
	// With open set the text is left unfinished for the next pattern to see.
	function automatic void build_text(bit open);
		bit [7:0] body[$];
		bit [7:0] b;
		int n;
		text_req_t r;
		n = verdicts.effective_length();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(6))
				body.insert(body.size(), 8'($urandom_range(255)));
		end else begin
			for (int i = 0; i < n; i++) begin
				b = verdicts.pattern_byte(i);
				if (b == STAR_BYTE)
					repeat ($urandom_range(3))
						body.insert(body.size(), any_letter());
				else
					body.insert(body.size(), b);
			end
			if ($urandom_range(99) < 30) begin
				case ($urandom_range(2))
				0: if (body.size() > 0)
					body[$urandom_range(body.size() - 1)] = any_letter();
				1: if (body.size() > 0)
					void'(body.pop_back());
				default: body.insert(body.size(), any_letter());
				endcase
			end
		end
		foreach (body[k]) begin
			if ($urandom_range(9) == 0)
				add_item(8'($urandom_range(255)), 1'b0, 1'b0);
			add_item(body[k], 1'b1, 1'b0);
		end
		if (!open) begin
			if (body.size() > 0 && $urandom_range(1) == 1) begin
				r = text_q.pop_back();
				r.end_of_text = 1'b1;
				text_q.insert(text_q.size(), r);
			end else begin
				add_item(8'($urandom_range(255)), 1'b0, 1'b1);
			end
		end
	endfunction

	task automatic run_random(int target);
		bit [8*PATTERN_MAX-1:0] w;
		bit [DATA_W-1:0] len_word;
		int start;
		start = sent_count;
		while (sent_count - start < target) begin
			random_pattern(w, len_word);
			program_pattern(w, len_word);
			repeat ($urandom_range(4, 1)) begin
				build_text(1'b0);
				send_text();
			end
			// leave a text open across the next pattern write
			if ($urandom_range(9) == 0) begin
				build_text(1'b1);
				send_text();
			end
		end
	endtask

	initial begin
		bit [8*PATTERN_MAX-1:0] w;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 29;
		rx_stall_pct  = 84;

		// Empty pattern after reset: only the empty text matches.
		add_item(8'h00, 1'b0, 1'b1);
		add_item("a", 1'b1, 1'b1);
		send_text();

		// The last literal must end the text, not merely occur in it.
		program_pattern(str_to_chars("*a"), 2);
		add_item("a", 1'b1, 1'b0);
		add_item("b", 1'b1, 1'b0);
		add_item("a", 1'b1, 1'b1);
		add_item("a", 1'b1, 1'b0);
		add_item("b", 1'b1, 1'b0);
		add_item(8'h55, 1'b0, 1'b1);
		send_text();

		// Lone star: swallow a zero byte and an all-ones byte.
		program_pattern(str_to_chars("*"), 1);
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b1);
		send_text();

		// Zero byte in the pattern cuts it short; a no-character request in the middle.
		w = str_to_chars("ab");
		w[31:24] = "c";
		program_pattern(w, 4);
		add_item("a", 1'b1, 1'b0);
		add_item(8'h3C, 1'b0, 1'b0);
		add_item("b", 1'b1, 1'b0);
		add_item(8'h00, 1'b0, 1'b1);
		send_text();

		// Full-width pattern, length field all ones so it saturates.
		w = {PATTERN_MAX{STAR_BYTE}};
		w[255:248] = 8'hFF;
		program_pattern(w, '1);
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b1);
		add_item(8'hFF, 1'b1, 1'b0);
		add_item(8'h80, 1'b1, 1'b1);
		send_text();

		// Rewrite mid-text: the reached position carries over to the new pattern.
		program_pattern(str_to_chars("ab"), 2);
		add_item("a", 1'b1, 1'b0);
		send_text();
		program_pattern(str_to_chars("xb"), 2);
		add_item("b", 1'b1, 1'b1);
		send_text();

		// Rewrite to a shorter pattern: positions past its end are dropped.
		program_pattern(str_to_chars("abc"), 3);
		add_item("a", 1'b1, 1'b0);
		add_item("b", 1'b1, 1'b0);
		send_text();
		program_pattern(str_to_chars("a"), 1);
		add_item(8'h00, 1'b0, 1'b1);
		send_text();

		run_random(PHASE_REQUESTS);

		send_idle_pct = 84;
		rx_stall_pct  = 29;
		run_random(PHASE_REQUESTS);

		send_idle_pct = 0;
		rx_stall_pct  = 0;
		run_random(PHASE_REQUESTS);

		// Drain: wait for the last verdicts, then wait out any strays.
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (verdicts.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		verdicts.check_drained();

		if (verdicts.mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
